[src/gepc_pkg.sv]
// Shared constants, types and modular arithmetic for the grid exit path counter.
`timescale 1ns / 1ps

package gepc_pkg;

  localparam int MAX_ROWS  = 64;
  localparam int MAX_COLS  = 64;
  localparam int MAX_MOVES = 64;

  localparam int WORD_W  = 30;
  localparam int ROW_W   = MAX_COLS * WORD_W;
  localparam int ROW_AW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_AW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_CW  = $clog2(MAX_ROWS + 1);
  localparam int COL_CW  = $clog2(MAX_COLS + 1);
  localparam int MOVE_CW = $clog2(MAX_MOVES + 1);
  localparam int STEP_W  = $clog2(MAX_ROWS + 2);

  localparam logic [WORD_W-1:0] PATH_MOD = WORD_W'(1000000007);
  localparam logic [WORD_W-1:0] WORD_ONE = WORD_W'(1);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [MAX_COLS-1:0][WORD_W-1:0] row_t;

  typedef struct packed {
    logic              top;
    logic              bot;
    logic [COL_CW-1:0] cols;
  } edge_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  function automatic word_t mod_add(input word_t a, input word_t b);
    logic [WORD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, PATH_MOD}) begin
      s = s - {1'b0, PATH_MOD};
    end
    return s[WORD_W-1:0];
  endfunction

endpackage

[src/gepc_row_ram.sv]
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module gepc_row_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/gepc_row_update.sv]
// One layer step for a whole grid row: modular sum of the four neighbours per cell.
`timescale 1ns / 1ps

module gepc_row_update import gepc_pkg::*; (
  input  row_t  up_i,
  input  row_t  mid_i,
  input  row_t  down_i,
  input  edge_t edge_i,
  output row_t  row_o
);

  for (genvar c = 0; c < MAX_COLS; c++) begin : g_lane
    word_t u, d, l, r;

    always_comb begin
      u = edge_i.top ? WORD_ONE : up_i[c];
      d = edge_i.bot ? WORD_ONE : down_i[c];
      if (c == 0) begin
        l = WORD_ONE;
      end else begin
        l = mid_i[(c == 0) ? 0 : c - 1];
      end
      if ((c == MAX_COLS - 1) || (COL_CW'(c + 1) == edge_i.cols)) begin
        r = WORD_ONE;
      end else begin
        r = mid_i[(c == MAX_COLS - 1) ? c : c + 1];
      end
      row_o[c] = mod_add(mod_add(u, d), mod_add(l, r));
    end
  end

endmodule

[src/grid_exit_path_count.sv]
// Top level: counts grid exit paths modulo 1000000007 by row-wide layer sweeps.
// A start outside the grid or a zero move budget skips the sweeps. One query is
// handled at a time; each layer sweeps the grid one row per cycle through the
// ping-pong row memories.
// Reset: asynchronous, active low; clears control state, memories need none.
`timescale 1ns / 1ps

module grid_exit_path_count import gepc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [6:0]        grid_rows_i,
  input  logic [6:0]        grid_cols_i,
  input  logic [6:0]        move_budget_i,
  input  logic [5:0]        start_row_i,
  input  logic [5:0]        start_col_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [WORD_W-1:0] path_count_o
);

  state_e              state_q, state_d;
  logic [ROW_CW-1:0]   rows_q, rows_d;
  logic [COL_CW-1:0]   cols_q, cols_d;
  logic [MOVE_CW-1:0]  budget_q, budget_d;
  logic [MOVE_CW-1:0]  layer_q, layer_d;
  logic [ROW_AW-1:0]   sr_q, sr_d;
  logic [COL_AW-1:0]   sc_q, sc_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic                par_q, par_d;
  row_t                up_q, up_d;
  row_t                mid_q, mid_d;
  word_t               res_q, res_d;
  logic                out_valid_q, out_valid_d;
  word_t               path_count_q, path_count_d;

  logic [ROW_CW-1:0]   rows_sat;
  logic [COL_CW-1:0]   cols_sat;
  logic [MOVE_CW-1:0]  budget_sat;
  logic                start_in;
  logic                rd_en;
  logic                comp_en;
  logic                last_step;
  logic [STEP_W-1:0]   m;
  row_t                even_rdata, odd_rdata, prev_row, new_row;
  edge_t               edge_s;

  always_comb begin
    if (int'(grid_rows_i) > MAX_ROWS) begin
      rows_sat = ROW_CW'(MAX_ROWS);
    end else begin
      rows_sat = ROW_CW'(grid_rows_i);
    end
    if (int'(grid_cols_i) > MAX_COLS) begin
      cols_sat = COL_CW'(MAX_COLS);
    end else begin
      cols_sat = COL_CW'(grid_cols_i);
    end
    if (int'(move_budget_i) > MAX_MOVES) begin
      budget_sat = MOVE_CW'(MAX_MOVES);
    end else begin
      budget_sat = MOVE_CW'(move_budget_i);
    end
    start_in = (int'(start_row_i) < int'(rows_sat)) && (int'(start_col_i) < int'(cols_sat));
  end

  assign m         = step_q - STEP_W'(2);
  assign rd_en     = (state_q == ST_RUN) && (step_q < STEP_W'(rows_q));
  assign comp_en   = (state_q == ST_RUN) && (step_q >= STEP_W'(2));
  assign last_step = step_q == (STEP_W'(rows_q) + STEP_W'(1));

  assign prev_row    = (layer_q == MOVE_CW'(1)) ? '0 : (par_q ? odd_rdata : even_rdata);
  assign edge_s.top  = m == '0;
  assign edge_s.bot  = m == (STEP_W'(rows_q) - STEP_W'(1));
  assign edge_s.cols = cols_q;

  gepc_row_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_ROWS)
  ) u_even_ram (
    .clk_i   (clk_i),
    .we_i    (comp_en && par_q),
    .waddr_i (m[ROW_AW-1:0]),
    .wdata_i (new_row),
    .re_i    (rd_en),
    .raddr_i (step_q[ROW_AW-1:0]),
    .rdata_o (even_rdata)
  );

  gepc_row_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_ROWS)
  ) u_odd_ram (
    .clk_i   (clk_i),
    .we_i    (comp_en && !par_q),
    .waddr_i (m[ROW_AW-1:0]),
    .wdata_i (new_row),
    .re_i    (rd_en),
    .raddr_i (step_q[ROW_AW-1:0]),
    .rdata_o (odd_rdata)
  );

  gepc_row_update u_row_update (
    .up_i   (up_q),
    .mid_i  (mid_q),
    .down_i (prev_row),
    .edge_i (edge_s),
    .row_o  (new_row)
  );

  always_comb begin
    state_d      = state_q;
    rows_d       = rows_q;
    cols_d       = cols_q;
    budget_d     = budget_q;
    layer_d      = layer_q;
    sr_d         = sr_q;
    sc_d         = sc_q;
    step_d       = step_q;
    par_d        = par_q;
    up_d         = up_q;
    mid_d        = mid_q;
    res_d        = res_q;
    out_valid_d  = out_valid_q && out_stall_i;
    path_count_d = path_count_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          rows_d   = rows_sat;
          cols_d   = cols_sat;
          budget_d = budget_sat;
          sr_d     = ROW_AW'(start_row_i);
          sc_d     = COL_AW'(start_col_i);
          layer_d  = MOVE_CW'(1);
          step_d   = '0;
          par_d    = 1'b0;
          if (!start_in) begin
            res_d   = WORD_ONE;
            state_d = ST_DONE;
          end else if (budget_sat == '0) begin
            res_d   = '0;
            state_d = ST_DONE;
          end else begin
            state_d = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        step_d = step_q + STEP_W'(1);
        if (step_q != '0) begin
          up_d  = mid_q;
          mid_d = prev_row;
        end
        if (comp_en && (layer_q == budget_q) && (m == STEP_W'(sr_q))) begin
          res_d = new_row[sc_q];
        end
        if (last_step) begin
          step_d  = '0;
          par_d   = !par_q;
          layer_d = layer_q + MOVE_CW'(1);
          if (layer_q == budget_q) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          path_count_d = res_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      layer_q     <= MOVE_CW'(1);
      step_q      <= '0;
      par_q       <= 1'b0;
      budget_q    <= MOVE_CW'(1);
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      layer_q     <= layer_d;
      step_q      <= step_d;
      par_q       <= par_d;
      budget_q    <= budget_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rows_q       <= rows_d;
    cols_q       <= cols_d;
    sr_q         <= sr_d;
    sc_q         <= sc_d;
    up_q         <= up_d;
    mid_q        <= mid_d;
    res_q        <= res_d;
    path_count_q <= path_count_d;
  end

  assign in_stall_o   = state_q != ST_IDLE;
  assign out_valid_o  = out_valid_q;
  assign path_count_o = path_count_q;

  a_result_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> path_count_o < PATH_MOD)
    else $error("result not reduced below the modulus");

  a_accept_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second transaction accepted while a query is in progress");

  a_layer_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (layer_q >= MOVE_CW'(1)) && (layer_q <= budget_q))
    else $error("layer counter outside the move budget");

  a_write_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    comp_en |-> (m < STEP_W'(rows_q)))
    else $error("row write beyond the grid in use");

endmodule

[bench/gepc_path_checker.sv]
// Checker for the grid exit path counter: predicts each count and compares results.
`timescale 1ns / 1ps

module gepc_path_checker import gepc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [6:0]        grid_rows_i,
  input  logic [6:0]        grid_cols_i,
  input  logic [6:0]        move_budget_i,
  input  logic [5:0]        start_row_i,
  input  logic [5:0]        start_col_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [WORD_W-1:0] path_count_i,
  output int unsigned       pending_o,
  output int unsigned       fail_count_o
);

  word_t       counts_due[$];
  word_t       due_count;
  int unsigned mismatches;

  assign fail_count_o = mismatches;

  function automatic word_t count_exit_paths(input logic [6:0] rows_in, input logic [6:0] cols_in,
                                             input logic [6:0] moves_in, input logic [5:0] srow,
                                             input logic [5:0] scol);
    int                  rows;
    int                  cols;
    int                  moves;
    longint unsigned     sum;
    word_t               prev_layer [MAX_ROWS][MAX_COLS];
    word_t               next_layer [MAX_ROWS][MAX_COLS];
    rows  = (rows_in > MAX_ROWS) ? MAX_ROWS : int'(rows_in);
    cols  = (cols_in > MAX_COLS) ? MAX_COLS : int'(cols_in);
    moves = (moves_in > MAX_MOVES) ? MAX_MOVES : int'(moves_in);
    if (int'(srow) >= rows || int'(scol) >= cols) begin
      return WORD_ONE;
    end
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        prev_layer[r][c] = '0;
      end
    end
    for (int k = 1; k <= moves; k++) begin
      for (int r = 0; r < rows; r++) begin
        for (int c = 0; c < cols; c++) begin
          sum = (r == 0)        ? 64'd1 : 64'(prev_layer[r-1][c]);
          sum += (r == rows - 1) ? 64'd1 : 64'(prev_layer[r+1][c]);
          sum += (c == 0)        ? 64'd1 : 64'(prev_layer[r][c-1]);
          sum += (c == cols - 1) ? 64'd1 : 64'(prev_layer[r][c+1]);
          next_layer[r][c] = word_t'(sum % 64'(PATH_MOD));
        end
      end
      for (int r = 0; r < rows; r++) begin
        for (int c = 0; c < cols; c++) begin
          prev_layer[r][c] = next_layer[r][c];
        end
      end
    end
    return prev_layer[srow][scol];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counts_due.delete();
      pending_o  <= 0;
      mismatches =  0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        counts_due.push_back(count_exit_paths(grid_rows_i, grid_cols_i, move_budget_i,
                                              start_row_i, start_col_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (counts_due.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: unexpected path_count transaction, actual %0d", $time, path_count_i);
          end
          mismatches++;
        end else begin
          due_count = counts_due.pop_front();
          if (due_count !== path_count_i) begin
            if (mismatches < 10) begin
              $display("%0t: path_count mismatch, expected %0d, actual %0d",
                       $time, due_count, path_count_i);
            end
            mismatches++;
          end
        end
      end
      pending_o <= counts_due.size();
    end
  end

endmodule

[bench/tb.sv]
// Testbench top for the grid exit path counter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb import gepc_pkg::*; ();

  localparam int RUN_LIMIT = 3_000_000;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid;
  logic              in_stall;
  logic [6:0]        grid_rows;
  logic [6:0]        grid_cols;
  logic [6:0]        move_budget;
  logic [5:0]        start_row;
  logic [5:0]        start_col;
  logic              out_valid;
  logic              out_stall;
  logic [WORD_W-1:0] path_count;
  int unsigned       pending;
  int unsigned       fail_count;
  int                sender_idle_pct;
  int                receiver_stall_pct;
  int unsigned       cycle_count;

  grid_exit_path_count u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .grid_rows_i   (grid_rows),
    .grid_cols_i   (grid_cols),
    .move_budget_i (move_budget),
    .start_row_i   (start_row),
    .start_col_i   (start_col),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .path_count_o  (path_count)
  );

  gepc_path_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .grid_rows_i   (grid_rows),
    .grid_cols_i   (grid_cols),
    .move_budget_i (move_budget),
    .start_row_i   (start_row),
    .start_col_i   (start_col),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .path_count_i  (path_count),
    .pending_o     (pending),
    .fail_count_o  (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count >= RUN_LIMIT) begin
        $display("grid_exit_path_count verification failed");
        $finish;
      end
    end
  end

  task automatic send_query(input logic [6:0] rows, input logic [6:0] cols,
                            input logic [6:0] moves, input logic [5:0] srow,
                            input logic [5:0] scol);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    grid_rows   <= rows;
    grid_cols   <= cols;
    move_budget <= moves;
    start_row   <= srow;
    start_col   <= scol;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  task automatic random_query();
    int         pick;
    int         rows_used;
    int         cols_used;
    logic [6:0] rows;
    logic [6:0] cols;
    logic [6:0] moves;
    logic [5:0] srow;
    logic [5:0] scol;
    pick = int'($urandom_range(0, 99));
    if (pick < 80) begin
      rows  = 7'($urandom_range(1, 8));
      cols  = 7'($urandom_range(1, 8));
      moves = 7'($urandom_range(0, 30));
    end else if (pick < 90) begin
      rows  = 7'($urandom_range(0, 127));
      cols  = 7'($urandom_range(0, 127));
      moves = 7'($urandom_range(0, 6));
    end else begin
      rows  = 7'($urandom_range(33, 127));
      cols  = 7'($urandom_range(33, 127));
      moves = 7'($urandom_range(0, 127));
    end
    rows_used = (rows > MAX_ROWS) ? MAX_ROWS : int'(rows);
    cols_used = (cols > MAX_COLS) ? MAX_COLS : int'(cols);
    if ($urandom_range(0, 99) < 88 && rows_used > 0 && cols_used > 0) begin
      srow = 6'($urandom_range(0, rows_used - 1));
      scol = 6'($urandom_range(0, cols_used - 1));
    end else begin
      srow = 6'($urandom_range(0, 63));
      scol = 6'($urandom_range(0, 63));
    end
    send_query(rows, cols, moves, srow, scol);
  endtask

  task automatic drain_counts();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int queries);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (queries) random_query();
    drain_counts();
  endtask

  initial begin
    rst_ni             = 1'b0;
    in_valid           = 1'b0;
    grid_rows          = '0;
    grid_cols          = '0;
    move_budget        = '0;
    start_row          = '0;
    start_col          = '0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_query(7'd1,   7'd1,   7'd0,   6'd0,  6'd0);
    send_query(7'd1,   7'd1,   7'd1,   6'd0,  6'd0);
    send_query(7'd1,   7'd1,   7'd64,  6'd0,  6'd0);
    send_query(7'd2,   7'd2,   7'd2,   6'd0,  6'd0);
    send_query(7'd1,   7'd3,   7'd3,   6'd0,  6'd1);
    send_query(7'd64,  7'd64,  7'd64,  6'd0,  6'd0);
    send_query(7'd64,  7'd64,  7'd64,  6'd63, 6'd63);
    send_query(7'd127, 7'd127, 7'd127, 6'd32, 6'd31);
    send_query(7'd0,   7'd5,   7'd3,   6'd0,  6'd0);
    send_query(7'd5,   7'd0,   7'd3,   6'd0,  6'd0);
    send_query(7'd0,   7'd0,   7'd0,   6'd63, 6'd63);
    send_query(7'd4,   7'd4,   7'd10,  6'd4,  6'd0);
    send_query(7'd4,   7'd4,   7'd10,  6'd0,  6'd4);
    send_query(7'd4,   7'd4,   7'd0,   6'd3,  6'd3);
    send_query(7'd65,  7'd1,   7'd127, 6'd63, 6'd0);
    send_query(7'd1,   7'd100, 7'd5,   6'd0,  6'd63);
    send_query(7'd3,   7'd3,   7'd127, 6'd1,  6'd1);
    send_query(7'd8,   7'd8,   7'd20,  6'd7,  6'd7);
    send_query(7'd64,  7'd64,  7'd0,   6'd63, 6'd63);
    send_query(7'd127, 7'd127, 7'd0,   6'd0,  6'd0);
    send_query(7'd2,   7'd64,  7'd64,  6'd1,  6'd42);
    send_query(7'd42,  7'd21,  7'd21,  6'd21, 6'd42);
    send_query(7'd42,  7'd21,  7'd85,  6'd21, 6'd20);

    run_phase(0,  0,  29);
    run_phase(82, 0,  29);
    run_phase(0,  82, 29);
    run_phase(33, 33, 29);

    repeat (100) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("grid_exit_path_count verification clean");
    end else begin
      $display("grid_exit_path_count verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
src/gepc_pkg.sv
src/gepc_row_ram.sv
src/gepc_row_update.sv
src/grid_exit_path_count.sv
bench/gepc_path_checker.sv
bench/tb.sv
